### rtl/mrsp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, event codes and length tables for the MIDI running status parser.
// No dependencies.
package mrsp_pkg;

  localparam int PORT_COUNT    = 3;
  localparam int PORT_W        = 2;
  localparam int PROGRAM_LIMIT = 64;
  localparam int SONG_LIMIT    = 16;

  localparam logic [23:0] FRAME_MAX  = 24'hFF_FFFF;
  localparam logic [15:0] BEND_FLIP  = 16'h8000;
  localparam logic [7:0]  SENSE_ALL  = 8'hFF;
  localparam logic [7:0]  SENSE_LOW  = 8'h0F;

  // event kinds
  localparam logic [3:0] EV_NONE     = 4'd0;
  localparam logic [3:0] EV_NOTE_ON  = 4'd1;
  localparam logic [3:0] EV_NOTE_OFF = 4'd2;
  localparam logic [3:0] EV_POLY     = 4'd3;
  localparam logic [3:0] EV_CONTROL  = 4'd4;
  localparam logic [3:0] EV_PROGRAM  = 4'd5;
  localparam logic [3:0] EV_CHAN_PRS = 4'd6;
  localparam logic [3:0] EV_BEND     = 4'd7;
  localparam logic [3:0] EV_LOCATE   = 4'd8;
  localparam logic [3:0] EV_SONG_SEL = 4'd9;
  localparam logic [3:0] EV_START    = 4'd10;
  localparam logic [3:0] EV_CONTINUE = 4'd11;
  localparam logic [3:0] EV_STOP     = 4'd12;
  localparam logic [3:0] EV_RESET    = 4'd13;
  localparam logic [3:0] EV_ERROR    = 4'd14;

  // per-port parse states
  localparam logic [1:0] PS_WAIT   = 2'd0;
  localparam logic [1:0] PS_ONE    = 2'd1;
  localparam logic [1:0] PS_FIRST  = 2'd2;
  localparam logic [1:0] PS_SECOND = 2'd3;

  // status high nibbles
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_POLY     = 4'hA;
  localparam logic [3:0] ST_CONTROL  = 4'hB;
  localparam logic [3:0] ST_PROGRAM  = 4'hC;
  localparam logic [3:0] ST_CHAN_PRS = 4'hD;
  localparam logic [3:0] ST_BEND     = 4'hE;
  localparam logic [3:0] ST_SYSTEM   = 4'hF;

  // system common low nibbles
  localparam logic [3:0] SC_SONG_POS = 4'h2;
  localparam logic [3:0] SC_SONG_SEL = 4'h3;

  // real-time codes (low three bits of 0xF8..0xFF)
  localparam logic [2:0] RT_CLOCK    = 3'd0;
  localparam logic [2:0] RT_START    = 3'd2;
  localparam logic [2:0] RT_CONTINUE = 3'd3;
  localparam logic [2:0] RT_STOP     = 3'd4;
  localparam logic [2:0] RT_SENSE    = 3'd6;
  localparam logic [2:0] RT_RESET    = 3'd7;

  // configuration register indexes
  localparam logic [1:0] REG_CLOCK_EN   = 2'd0;
  localparam logic [1:0] REG_CLOCK_SRC  = 2'd1;
  localparam logic [1:0] REG_PROG_CHAN  = 2'd2;

  // parse state after a channel status, by bits 6:4
  function automatic logic [1:0] chan_len(input logic [2:0] code);
    logic [1:0] r;
    case (code)
      3'd4, 3'd5: r = PS_ONE;
      3'd7:       r = PS_WAIT;
      default:    r = PS_FIRST;
    endcase
    return r;
  endfunction

  // parse state after a system common status, by bits 2:0
  function automatic logic [1:0] common_len(input logic [2:0] code);
    logic [1:0] r;
    case (code)
      3'd2:    r = PS_FIRST;
      3'd3:    r = PS_ONE;
      default: r = PS_WAIT;
    endcase
    return r;
  endfunction

endpackage

### rtl/midi_running_status_parser.sv
`timescale 1ns / 1ps
// MIDI byte parser with running status: input register, per-port parse state and result register.
// Depends on mrsp_pkg.

// Takes one received byte per cycle unless stalled, with its port number, and returns exactly one
// decoded event per byte. A byte lands in the input register, and in the cycle it moves on to the
// result register the per-port state (parse state, running status, held data byte, sensing flags)
// and the shared transport (run flag, frame position) are updated in the same single pass.
// Throughput is one byte per cycle unless stalled. The input register keeps taking bytes while a
// result waits, until both registers are full. Configuration registers sit behind an APB port at
// byte addresses 0, 4 and 8; the user must write them only while idle, unenforced by the block.
module midi_running_status_parser
  import mrsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PORT_W-1:0] in_port,
  input  logic [7:0]        in_rx_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_event_kind,
  output logic [PORT_W-1:0] out_event_port,
  output logic [3:0]        out_event_channel,
  output logic [6:0]        out_first_data,
  output logic [6:0]        out_second_data,
  output logic [15:0]       out_bend_value,
  output logic [23:0]       out_frame_position,
  output logic              out_transport_running,
  output logic [7:0]        out_sense_flags,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration registers
  logic       clock_en_r;
  logic       clock_src_r;
  logic [4:0] prog_chan_r;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_en_r  <= 1'b0;
      clock_src_r <= 1'b0;
      prog_chan_r <= 5'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_CLOCK_EN:  clock_en_r  <= pwdata[0];
        REG_CLOCK_SRC: clock_src_r <= pwdata[0];
        REG_PROG_CHAN: prog_chan_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CLOCK_EN:  prdata = {31'd0, clock_en_r};
      REG_CLOCK_SRC: prdata = {31'd0, clock_src_r};
      REG_PROG_CHAN: prdata = {27'd0, prog_chan_r};
      default:       prdata = 32'd0;
    endcase
  end

  // input register
  logic              in_valid_r;
  logic [PORT_W-1:0] in_port_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r;
  logic              advance;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_port_r <= in_port;
      in_byte_r <= in_rx_byte;
    end
  end

  // per-port and transport state
  logic [1:0]  ps_r  [PORT_COUNT];
  logic [7:0]  rs_r  [PORT_COUNT];
  logic [6:0]  hd_r  [PORT_COUNT];
  logic [7:0]  sf_r  [PORT_COUNT];
  logic [1:0]  ps_nxt[PORT_COUNT];
  logic [7:0]  rs_nxt[PORT_COUNT];
  logic [6:0]  hd_nxt[PORT_COUNT];
  logic [7:0]  sf_nxt[PORT_COUNT];
  logic        run_r, run_nxt;
  logic [23:0] frame_r, frame_nxt;

  // result fields of the current byte
  logic [3:0]  kind_nxt;
  logic [3:0]  chan_nxt;
  logic [6:0]  d1_nxt;
  logic [6:0]  d2_nxt;
  logic [15:0] bend_nxt;
  logic [7:0]  sense_nxt;

  logic              p_ok;
  logic [PORT_W-1:0] p;
  logic [7:0]        b;
  logic [6:0]        bd;
  logic [1:0]        st;
  logic [3:0]        hi;
  logic [3:0]        lo;
  logic [6:0]        a;
  logic [24:0]       clk_sum;
  logic [17:0]       pos18;
  logic [17:0]       locate_frames;

  assign p    = in_port_r;
  assign b    = in_byte_r;
  assign bd   = in_byte_r[6:0];
  assign p_ok = {{(32-PORT_W){1'b0}}, in_port_r} < PORT_COUNT;
  assign st   = p_ok ? ps_r[p] : PS_WAIT;
  assign hi   = p_ok ? rs_r[p][7:4] : 4'd0;
  assign lo   = p_ok ? rs_r[p][3:0] : 4'd0;
  assign a    = p_ok ? hd_r[p] : 7'd0;

  assign clk_sum       = {1'b0, frame_r} + 25'd2;
  assign pos18         = {4'd0, bd, a};
  assign locate_frames = (pos18 << 3) + (pos18 << 2);

  always_comb begin
    for (int i = 0; i < PORT_COUNT; i++) begin
      ps_nxt[i] = ps_r[i];
      rs_nxt[i] = rs_r[i];
      hd_nxt[i] = hd_r[i];
      sf_nxt[i] = sf_r[i];
    end
    run_nxt   = run_r;
    frame_nxt = frame_r;
    kind_nxt  = EV_NONE;
    chan_nxt  = 4'd0;
    d1_nxt    = 7'd0;
    d2_nxt    = 7'd0;
    bend_nxt  = 16'd0;
    sense_nxt = 8'd0;

    if (p_ok) begin
      // refresh sensing before the byte itself
      if (sf_r[p] != 8'd0) begin
        sf_nxt[p] = sf_r[p] | SENSE_LOW;
      end

      if (b[7]) begin
        if (b[6:4] != 3'd7) begin
          ps_nxt[p] = chan_len(b[6:4]);
          rs_nxt[p] = b;
        end else if (!b[3]) begin
          ps_nxt[p] = common_len(b[2:0]);
          rs_nxt[p] = b;
        end else begin
          case (b[2:0])
            RT_CLOCK: begin
              if (clock_en_r && run_r) begin
                frame_nxt = clk_sum[24] ? FRAME_MAX : clk_sum[23:0];
              end
            end
            RT_START: begin
              if (clock_src_r && !run_r) begin
                run_nxt   = 1'b1;
                frame_nxt = 24'd0;
                kind_nxt  = EV_START;
              end
            end
            RT_CONTINUE: begin
              if (clock_src_r && !run_r) begin
                run_nxt  = 1'b1;
                kind_nxt = EV_CONTINUE;
              end
            end
            RT_STOP: begin
              if (clock_src_r && run_r) begin
                run_nxt  = 1'b0;
                kind_nxt = EV_STOP;
              end
            end
            RT_SENSE: sf_nxt[p] = SENSE_ALL;
            RT_RESET: begin
              for (int i = 0; i < PORT_COUNT; i++) begin
                ps_nxt[i] = PS_WAIT;
                rs_nxt[i] = 8'd0;
                sf_nxt[i] = 8'd0;
              end
              kind_nxt = EV_RESET;
            end
            default: ;
          endcase
        end
      end else begin
        unique case (st)
          PS_WAIT: ;
          PS_ONE: begin
            if (hi == ST_PROGRAM) begin
              if (p == '0 && ({1'b0, lo} + 5'd1) == prog_chan_r &&
                  {1'b0, bd} < 8'(PROGRAM_LIMIT)) begin
                kind_nxt = EV_PROGRAM;
                chan_nxt = lo;
                d1_nxt   = bd;
              end
            end else if (hi == ST_CHAN_PRS) begin
              kind_nxt = EV_CHAN_PRS;
              chan_nxt = lo;
              d2_nxt   = bd;
            end else if (hi == ST_SYSTEM && lo == SC_SONG_SEL && !run_r) begin
              if ({1'b0, bd} < 8'(SONG_LIMIT)) begin
                kind_nxt = EV_SONG_SEL;
                d1_nxt   = bd;
              end
            end else begin
              ps_nxt[p] = PS_WAIT;
              rs_nxt[p] = 8'd0;
              kind_nxt  = EV_ERROR;
            end
          end
          PS_FIRST: begin
            hd_nxt[p] = bd;
            ps_nxt[p] = PS_SECOND;
          end
          PS_SECOND: begin
            ps_nxt[p] = PS_FIRST;
            case (hi)
              ST_NOTE_ON, ST_NOTE_OFF, ST_POLY, ST_CONTROL, ST_BEND: begin
                chan_nxt = lo;
                d1_nxt   = a;
                d2_nxt   = bd;
                case (hi)
                  ST_NOTE_ON: kind_nxt = (bd != 7'd0) ? EV_NOTE_ON : EV_NOTE_OFF;
                  ST_NOTE_OFF: kind_nxt = EV_NOTE_OFF;
                  ST_POLY:     kind_nxt = EV_POLY;
                  ST_CONTROL:  kind_nxt = EV_CONTROL;
                  default: begin
                    kind_nxt = EV_BEND;
                    bend_nxt = {bd, a, 2'b00} ^ BEND_FLIP;
                  end
                endcase
              end
              ST_SYSTEM: begin
                if (lo == SC_SONG_POS) begin
                  if (clock_src_r && !run_r) begin
                    frame_nxt = {6'd0, locate_frames};
                    kind_nxt  = EV_LOCATE;
                    d1_nxt    = a;
                    d2_nxt    = bd;
                  end
                end else begin
                  ps_nxt[p] = PS_WAIT;
                  rs_nxt[p] = 8'd0;
                  kind_nxt  = EV_ERROR;
                end
              end
              default: begin
                ps_nxt[p] = PS_WAIT;
                rs_nxt[p] = 8'd0;
                kind_nxt  = EV_ERROR;
              end
            endcase
          end
        endcase
      end
      sense_nxt = sf_nxt[p];
    end
  end

  // commit state as the byte moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        ps_r[i] <= PS_WAIT;
        rs_r[i] <= 8'd0;
        hd_r[i] <= 7'd0;
        sf_r[i] <= 8'd0;
      end
      run_r   <= 1'b0;
      frame_r <= 24'd0;
    end else if (advance) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        ps_r[i] <= ps_nxt[i];
        rs_r[i] <= rs_nxt[i];
        hd_r[i] <= hd_nxt[i];
        sf_r[i] <= sf_nxt[i];
      end
      run_r   <= run_nxt;
      frame_r <= frame_nxt;
    end
  end

  // result register
  logic [3:0]        kind_r;
  logic [PORT_W-1:0] port_r;
  logic [3:0]        chan_r;
  logic [6:0]        d1_r;
  logic [6:0]        d2_r;
  logic [15:0]       bend_r;
  logic [23:0]       pos_r;
  logic              running_r;
  logic [7:0]        sense_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind_r    <= kind_nxt;
      port_r    <= p;
      chan_r    <= chan_nxt;
      d1_r      <= d1_nxt;
      d2_r      <= d2_nxt;
      bend_r    <= bend_nxt;
      pos_r     <= frame_nxt;
      running_r <= run_nxt;
      sense_r   <= sense_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_event_kind        = kind_r;
  assign out_event_port        = port_r;
  assign out_event_channel     = chan_r;
  assign out_first_data        = d1_r;
  assign out_second_data       = d2_r;
  assign out_bend_value        = bend_r;
  assign out_frame_position    = pos_r;
  assign out_transport_running = running_r;
  assign out_sense_flags       = sense_r;

  // transport changes only with the matching event in the result register
  a_run_rise : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(run_r) |-> (out_valid_r && (kind_r == EV_START || kind_r == EV_CONTINUE)))
    else $error("run flag set without start or continue");

  a_run_fall : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(run_r) |-> (out_valid_r && kind_r == EV_STOP))
    else $error("run flag cleared without stop");

  a_reset_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == EV_RESET) |-> (sense_r == 8'd0 && ps_r[port_r] == PS_WAIT))
    else $error("system reset left port state behind");

  a_error_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == EV_ERROR) |-> (ps_r[port_r] == PS_WAIT && rs_r[port_r] == 8'd0))
    else $error("error event without port reset");

endmodule

### tb/mrsp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the MIDI running status parser: watches the byte, event and register ports,
// predicts each event from its own copy of the parser state and compares. Depends on mrsp_pkg.
module mrsp_checker
  import mrsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [PORT_W-1:0] in_port,
  input  logic [7:0]        in_rx_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [3:0]        out_event_kind,
  input  logic [PORT_W-1:0] out_event_port,
  input  logic [3:0]        out_event_channel,
  input  logic [6:0]        out_first_data,
  input  logic [6:0]        out_second_data,
  input  logic [15:0]       out_bend_value,
  input  logic [23:0]       out_frame_position,
  input  logic              out_transport_running,
  input  logic [7:0]        out_sense_flags,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [3:0]        kind;
    logic [PORT_W-1:0] port;
    logic [3:0]        chan;
    logic [6:0]        d1;
    logic [6:0]        d2;
    logic [15:0]       bend;
    logic [23:0]       frame;
    logic              run;
    logic [7:0]        sense;
  } midi_event_t;

  // parser state copy
  logic [1:0] port_phase  [PORT_COUNT];
  logic [7:0] port_status [PORT_COUNT];
  logic [6:0] port_held   [PORT_COUNT];
  logic [7:0] port_sense  [PORT_COUNT];
  logic       transport_run;
  logic [23:0] frame_pos;

  // register copy
  logic       cfg_clock_en;
  logic       cfg_midi_src;
  logic [4:0] cfg_prog_chan;

  midi_event_t expected_events[$];
  int          mismatch_count = 0;

  task automatic clear_parser();
    for (int i = 0; i < PORT_COUNT; i++) begin
      port_phase[i]  = PS_WAIT;
      port_status[i] = '0;
      port_held[i]   = '0;
      port_sense[i]  = '0;
    end
    transport_run = 1'b0;
    frame_pos     = '0;
    cfg_clock_en  = 1'b0;
    cfg_midi_src  = 1'b0;
    cfg_prog_chan = '0;
  endtask

  // advance the parser copy by one byte and build the event it reports
  task automatic decode_midi_byte(input logic [PORT_W-1:0] p, input logic [7:0] b,
                                  output midi_event_t ev);
    logic [1:0]  st;
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [6:0]  a;
    logic [6:0]  d;
    logic [24:0] sum;
    ev      = '0;
    ev.port = p;
    if (p < PORT_COUNT) begin
      st = port_phase[p];
      hi = port_status[p][7:4];
      lo = port_status[p][3:0];
      a  = port_held[p];
      d  = b[6:0];
      if (port_sense[p] != '0) port_sense[p] = port_sense[p] | SENSE_LOW;
      if (b[7]) begin
        if (b[7:4] != ST_SYSTEM) begin
          case (b[7:4])
            ST_PROGRAM, ST_CHAN_PRS: port_phase[p] = PS_ONE;
            default:                 port_phase[p] = PS_FIRST;
          endcase
          port_status[p] = b;
        end else if (!b[3]) begin
          if (b[3:0] == SC_SONG_POS)      port_phase[p] = PS_FIRST;
          else if (b[3:0] == SC_SONG_SEL) port_phase[p] = PS_ONE;
          else                            port_phase[p] = PS_WAIT;
          port_status[p] = b;
        end else begin
          case (b[2:0])
            RT_CLOCK: begin
              if (cfg_clock_en && transport_run) begin
                sum = {1'b0, frame_pos} + 25'd2;
                frame_pos = (sum > {1'b0, FRAME_MAX}) ? FRAME_MAX : sum[23:0];
              end
            end
            RT_START: begin
              if (cfg_midi_src && !transport_run) begin
                transport_run = 1'b1;
                frame_pos     = '0;
                ev.kind       = EV_START;
              end
            end
            RT_CONTINUE: begin
              if (cfg_midi_src && !transport_run) begin
                transport_run = 1'b1;
                ev.kind       = EV_CONTINUE;
              end
            end
            RT_STOP: begin
              if (cfg_midi_src && transport_run) begin
                transport_run = 1'b0;
                ev.kind       = EV_STOP;
              end
            end
            RT_SENSE: port_sense[p] = SENSE_ALL;
            RT_RESET: begin
              for (int i = 0; i < PORT_COUNT; i++) begin
                port_phase[i]  = PS_WAIT;
                port_status[i] = '0;
                port_sense[i]  = '0;
              end
              ev.kind = EV_RESET;
            end
            default: ;
          endcase
        end
      end else begin
        case (st)
          PS_ONE: begin
            if (hi == ST_PROGRAM) begin
              if (p == 0 && ({1'b0, lo} + 5'd1) == cfg_prog_chan && b < PROGRAM_LIMIT) begin
                ev.kind = EV_PROGRAM;
                ev.chan = lo;
                ev.d1   = d;
              end
            end else if (hi == ST_CHAN_PRS) begin
              ev.kind = EV_CHAN_PRS;
              ev.chan = lo;
              ev.d2   = d;
            end else if (hi == ST_SYSTEM && lo == SC_SONG_SEL && !transport_run) begin
              if (b < SONG_LIMIT) begin
                ev.kind = EV_SONG_SEL;
                ev.d1   = d;
              end
            end else begin
              port_phase[p]  = PS_WAIT;
              port_status[p] = '0;
              ev.kind        = EV_ERROR;
            end
          end
          PS_FIRST: begin
            port_held[p]  = d;
            port_phase[p] = PS_SECOND;
          end
          PS_SECOND: begin
            port_phase[p] = PS_FIRST;
            case (hi)
              ST_NOTE_ON, ST_NOTE_OFF, ST_POLY, ST_CONTROL, ST_BEND: begin
                ev.chan = lo;
                ev.d1   = a;
                ev.d2   = d;
                case (hi)
                  ST_NOTE_ON:  ev.kind = (d != '0) ? EV_NOTE_ON : EV_NOTE_OFF;
                  ST_NOTE_OFF: ev.kind = EV_NOTE_OFF;
                  ST_POLY:     ev.kind = EV_POLY;
                  ST_CONTROL:  ev.kind = EV_CONTROL;
                  default: begin
                    ev.kind = EV_BEND;
                    ev.bend = ({d, 9'd0} | {7'd0, a, 2'd0}) ^ BEND_FLIP;
                  end
                endcase
              end
              ST_SYSTEM: begin
                if (lo == SC_SONG_POS) begin
                  if (cfg_midi_src && !transport_run) begin
                    frame_pos = {10'd0, d, a} * 24'd12;
                    ev.kind   = EV_LOCATE;
                    ev.d1     = a;
                    ev.d2     = d;
                  end
                end else begin
                  port_phase[p]  = PS_WAIT;
                  port_status[p] = '0;
                  ev.kind        = EV_ERROR;
                end
              end
              default: begin
                port_phase[p]  = PS_WAIT;
                port_status[p] = '0;
                ev.kind        = EV_ERROR;
              end
            endcase
          end
          default: ;
        endcase
      end
      ev.sense = port_sense[p];
    end
    ev.frame = frame_pos;
    ev.run   = transport_run;
  endtask

  task automatic check_field(input string name, input logic [23:0] want_v,
                             input logic [23:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    midi_event_t got;
    midi_event_t want;
    midi_event_t pred;
    if (!rst_n) begin
      clear_parser();
      expected_events.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.kind  = out_event_kind;
        got.port  = out_event_port;
        got.chan  = out_event_channel;
        got.d1    = out_first_data;
        got.d2    = out_second_data;
        got.bend  = out_bend_value;
        got.frame = out_frame_position;
        got.run   = out_transport_running;
        got.sense = out_sense_flags;
        if (expected_events.size() == 0) begin
          $display("%0t: event with nothing expected, expected none, actual kind %0d port %0d",
                   $time, got.kind, got.port);
          mismatch_count++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", 24'(want.kind), 24'(got.kind));
          check_field("event_port", 24'(want.port), 24'(got.port));
          check_field("event_channel", 24'(want.chan), 24'(got.chan));
          check_field("first_data", 24'(want.d1), 24'(got.d1));
          check_field("second_data", 24'(want.d2), 24'(got.d2));
          check_field("bend_value", 24'(want.bend), 24'(got.bend));
          check_field("frame_position", want.frame, got.frame);
          check_field("transport_running", 24'(want.run), 24'(got.run));
          check_field("sense_flags", 24'(want.sense), 24'(got.sense));
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {REG_CLOCK_EN, 2'b00}:  cfg_clock_en  = pwdata[0];
          {REG_CLOCK_SRC, 2'b00}: cfg_midi_src  = pwdata[0];
          {REG_PROG_CHAN, 2'b00}: cfg_prog_chan = pwdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        decode_midi_byte(in_port, in_rx_byte, pred);
        expected_events.push_back(pred);
      end
    end
    fail_count <= mismatch_count;
    pending    <= expected_events.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the MIDI parser testbench: clock, reset, byte and register stimulus, event stalls
// and the verdict. Depends on mrsp_pkg, mrsp_checker and midi_running_status_parser.
module tb_top;
  import mrsp_pkg::*;

  localparam logic [4:0] RT_PREFIX = 5'h1F;
  localparam int PHASE_ITEMS = 150;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PORT_W-1:0] in_port = '0;
  logic [7:0]        in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [3:0]        out_event_kind;
  logic [PORT_W-1:0] out_event_port;
  logic [3:0]        out_event_channel;
  logic [6:0]        out_first_data;
  logic [6:0]        out_second_data;
  logic [15:0]       out_bend_value;
  logic [23:0]       out_frame_position;
  logic              out_transport_running;
  logic [7:0]        out_sense_flags;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int pending;

  int         burst_left = 1;
  int         stall_mode = 0;
  int         stall_left = 0;
  int         stall_tick = 0;
  logic [4:0] cur_prog_chan = '0;

  always #5 clk = ~clk;

  midi_running_status_parser u_top (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_port, .in_rx_byte,
    .out_valid, .out_ready, .out_event_kind, .out_event_port, .out_event_channel,
    .out_first_data, .out_second_data, .out_bend_value, .out_frame_position,
    .out_transport_running, .out_sense_flags,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mrsp_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_port, .in_rx_byte,
    .out_valid, .out_ready, .out_event_kind, .out_event_port, .out_event_channel,
    .out_first_data, .out_second_data, .out_bend_value, .out_frame_position,
    .out_transport_running, .out_sense_flags,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending
  );

  // event side stalls: switch between always ready, random, sparse and periodic
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom);
      2:       out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= (stall_tick % 5) < 3;
    endcase
  end

  function automatic logic [7:0] realtime_byte(input logic [2:0] code);
    return {RT_PREFIX, code};
  endfunction

  // data byte with the extremes weighted up
  function automatic logic [7:0] data_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'h7F;
    return 8'($urandom_range(0, 127));
  endfunction

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // one transfer on the byte channel, then an idle gap at the end of a burst
  task automatic send_byte(input logic [PORT_W-1:0] p, input logic [7:0] b);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_port    <= p;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      pause($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // upper bits of the write data are random and must be dropped by the block
  task automatic set_config(input logic en, input logic src, input logic [4:0] chan);
    wait_drained();
    reg_write(REG_CLOCK_EN, ($urandom & ~32'h1) | {31'd0, en});
    reg_write(REG_CLOCK_SRC, ($urandom & ~32'h1) | {31'd0, src});
    reg_write(REG_PROG_CHAN, ($urandom & ~32'h1F) | {27'd0, chan});
    cur_prog_chan = chan;
  endtask

  // mostly well-formed messages with random content, some broken ones and noise
  task automatic send_random_message(output int counted);
    logic [PORT_W-1:0] p;
    logic [3:0]        hi;
    logic [3:0]        chan;
    logic [9:0]        seq[$];
    int                pick;
    int                n;
    bit                noise;
    p     = ($urandom_range(0, 19) == 0) ? PORT_W'(3) : PORT_W'($urandom_range(0, 2));
    chan  = 4'($urandom);
    pick  = $urandom_range(0, 99);
    noise = 1'b0;
    if (pick < 55) begin
      hi = 4'($urandom_range(8, 14));
      if (hi == ST_PROGRAM && cur_prog_chan != 0 && cur_prog_chan <= 16 && $urandom_range(0, 1)) begin
        p    = '0;
        chan = 4'(cur_prog_chan - 5'd1);
      end
      // leave out the status now and then to lean on running status
      if ($urandom_range(0, 3) != 0) seq.push_back({p, hi, chan});
      n = (hi == ST_PROGRAM || hi == ST_CHAN_PRS) ? 1 : 2;
      repeat (n) seq.push_back({p, data_byte()});
    end else if (pick < 63) begin
      if ($urandom_range(0, 3) != 0) seq.push_back({p, ST_SYSTEM, SC_SONG_POS});
      seq.push_back({p, data_byte()});
      seq.push_back({p, data_byte()});
    end else if (pick < 70) begin
      seq.push_back({p, ST_SYSTEM, SC_SONG_SEL});
      seq.push_back({p, ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 20)) : data_byte()});
    end else if (pick < 85) begin
      n = $urandom_range(0, 7);
      if (n == RT_RESET && $urandom_range(0, 7) != 0) n = RT_START;
      seq.push_back({p, realtime_byte(3'(n))});
    end else if (pick < 92) begin
      // short message: status followed by at most one data byte
      seq.push_back({p, 4'($urandom_range(8, 15)), chan});
      if ($urandom_range(0, 1)) seq.push_back({p, data_byte()});
    end else begin
      noise = 1'b1;
      repeat ($urandom_range(1, 3)) seq.push_back({p, 8'($urandom)});
    end
    // real-time bytes other than reset may land between any two bytes, from any port
    if (seq.size() > 1 && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(0, 6);
      if (n == RT_RESET) n = RT_SENSE;
      seq.insert($urandom_range(1, seq.size() - 1),
                 {PORT_W'($urandom_range(0, 3)), realtime_byte(3'(n))});
    end
    counted = noise ? 0 : seq.size();
    foreach (seq[i]) send_byte(seq[i][9:8], seq[i][7:0]);
  endtask

  initial begin
    logic       en;
    logic       src;
    logic [4:0] chan;
    int         sent;
    int         got;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_config(1'b1, 1'b1, 5'd1);
    send_byte(1, realtime_byte(RT_SENSE));
    send_byte(0, {ST_NOTE_ON, 4'hF});
    send_byte(0, 8'h00);
    send_byte(0, 8'h7F);
    // running status, zero velocity
    send_byte(0, 8'h3C);
    send_byte(0, 8'h00);
    send_byte(1, {ST_BEND, 4'h0});
    send_byte(1, 8'h00);
    send_byte(1, 8'h00);
    send_byte(1, 8'h7F);
    send_byte(1, 8'h7F);
    send_byte(0, {ST_PROGRAM, 4'h0});
    send_byte(0, 8'h05);
    send_byte(0, 8'h40);
    send_byte(2, {ST_CHAN_PRS, 4'h3});
    send_byte(2, 8'h55);
    send_byte(2, {ST_POLY, 4'h1});
    send_byte(2, 8'h10);
    send_byte(2, 8'h20);
    send_byte(2, {ST_CONTROL, 4'h2});
    send_byte(2, 8'h07);
    send_byte(2, 8'h64);
    send_byte(2, {ST_NOTE_OFF, 4'h0});
    send_byte(2, 8'h7F);
    send_byte(2, 8'h7F);
    send_byte(0, {ST_SYSTEM, SC_SONG_POS});
    send_byte(0, 8'h10);
    send_byte(0, 8'h02);
    send_byte(0, {ST_SYSTEM, SC_SONG_SEL});
    send_byte(0, 8'h05);
    send_byte(0, 8'h10);
    send_byte(0, realtime_byte(RT_START));
    send_byte(0, realtime_byte(RT_CLOCK));
    // song select while running
    send_byte(0, 8'h02);
    send_byte(2, realtime_byte(RT_STOP));
    send_byte(2, realtime_byte(RT_CONTINUE));
    send_byte(3, {ST_NOTE_ON, 4'h0});
    send_byte(1, {ST_SYSTEM, 4'h0});
    send_byte(1, 8'h12);
    send_byte(1, realtime_byte(3'd1));
    send_byte(0, realtime_byte(RT_RESET));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin en = 1'b1; src = 1'b1; chan = 5'd1; end
        1: begin en = 1'b0; src = 1'b0; chan = 5'd0; end
        2: begin en = 1'b1; src = 1'b1; chan = 5'd16; end
        3: begin en = 1'b0; src = 1'b1; chan = 5'd31; end
        4: begin en = 1'b1; src = 1'b0; chan = 5'd17; end
        5: begin en = 1'b1; src = 1'b1; chan = 5'($urandom_range(1, 16)); end
        6: begin en = 1'($urandom); src = 1'($urandom); chan = 5'($urandom); end
        default: begin en = 1'b1; src = 1'b1; chan = 5'd1; end
      endcase
      if (ph != 0) set_config(en, src, chan);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_message(got);
        sent += got;
        // in phase 4, hold off once mid-phase until every event is back
        if (ph == 4 && sent >= PHASE_ITEMS / 2 && sent - got < PHASE_ITEMS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
rtl/mrsp_pkg.sv
rtl/midi_running_status_parser.sv
tb/mrsp_checker.sv
tb/tb_top.sv
